### src/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cda_pkg;

    // Operation codes carried on the request side
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_CMP  = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_RANGE   = 2'd2;

    // Calendar constants
    localparam logic [13:0] MAX_YEAR     = 14'd9999;
    localparam logic [13:0] DEF_YEAR     = 14'd1900;
    localparam logic [3:0]  MONTHS       = 4'd12;
    localparam logic [6:0]  CENTURY      = 7'd100;
    localparam logic [23:0] DEF_SERIAL   = 24'd693595;   // 1900-01-01
    localparam logic [22:0] MAX_SERIAL   = 23'd3652058;  // 9999-12-31
    localparam logic [23:0] DAYS_400Y    = 24'd146097;
    localparam logic [23:0] DAYS_100Y    = 24'd36524;
    localparam logic [23:0] DAYS_4Y      = 24'd1461;
    localparam logic [23:0] DAYS_1Y      = 24'd365;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_CENT,
        S_BASE,
        S_MON,
        S_CHECK,
        S_RANGE,
        S_Q400,
        S_Q100,
        S_Q4,
        S_Q1,
        S_DMON,
        S_OUT
    } state_t;

    // Month length; months outside 1..12 read as 31
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        n = 5'd31;
        if (m >= 4'd1 && m <= MONTHS) begin
            n = MONTH_LEN[m - 4'd1];
        end
        if (m == 4'd2 && leap) begin
            n = 5'd29;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### src/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
`default_nettype none

// Gregorian date unit. Holds one date and runs one request at a time.
// Request channel (s_): s_tuser carries the opcode (load, add days, compare,
// no-op); s_tdata carries the operand date and the signed day offset.
// Result channel (m_): one result per request with the held date after the
// operation, the day difference and compare flags, and a status code.
// A request is taken only while the sequencer is idle; s_tready is low for
// the whole run. The shared adder converts a date to a day serial by
// stepping off centuries and then summing month lengths, and converts a
// serial back to a date by stepping off 400-, 100-, 4- and 1-year blocks
// and then months. A compare runs two date conversions; the century loop
// makes up most of a run, and a no-op skips the conversions. The sequencer
// returns to idle as its result is registered.
// The finished result sits in an output register; the block keeps it until
// m_tready takes it and accepts the next request meanwhile, holding the
// following result in its final state until the register frees up.
// Reset (aresetn low at a clock edge) sets the held date to 1998-08-28,
// returns to idle and drops any pending result.

module calendar_date_arithmetic (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [13:0] in_year, [17:14] in_month, [22:18] in_day, [45:23] day_offset
    input  wire logic [47:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [13:0] out_year, [17:14] out_month, [22:18] out_day,
    // [45:23] day_difference, [46] is_greater, [47] is_equal, [48] is_less,
    // [50:49] status
    output logic [55:0]      m_tdata
);
    import cda_pkg::*;

    // Sequencer state
    state_t      state_reg, state_next;

    // Held date
    logic [13:0] cur_year_reg, cur_year_next;
    logic [3:0]  cur_month_reg, cur_month_next;
    logic [4:0]  cur_day_reg, cur_day_next;

    // Latched request
    logic [1:0]  op_reg, op_next;
    logic [22:0] off_reg, off_next;

    // Working date and accumulator
    logic [13:0] yr_reg, yr_next;
    logic [3:0]  mo_reg, mo_next;
    logic [4:0]  dy_reg, dy_next;
    logic [23:0] acc_reg, acc_next;
    logic [23:0] opser_reg, opser_next;
    logic [7:0]  cent_reg, cent_next;
    logic [3:0]  k_reg, k_next;
    logic        leap_reg, leap_next;
    logic        pass_reg, pass_next;
    logic [1:0]  b_reg, b_next;
    logic [4:0]  c_reg, c_next;
    logic [1:0]  d_reg, d_next;
    logic [1:0]  status_reg, status_next;

    // Result register
    logic        m_valid_reg, m_valid_next;
    logic [13:0] o_year_reg, o_year_next;
    logic [3:0]  o_month_reg, o_month_next;
    logic [4:0]  o_day_reg, o_day_next;
    logic [22:0] o_diff_reg, o_diff_next;
    logic        o_gt_reg, o_gt_next;
    logic        o_eq_reg, o_eq_next;
    logic        o_lt_reg, o_lt_next;
    logic [1:0]  o_status_reg, o_status_next;

    // Request fields
    logic [1:0]  in_op;
    logic [13:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [22:0] in_off;

    // Shared adder
    logic [23:0] alu_b;
    logic        alu_sub;
    logic [23:0] alu_res;
    logic        alu_neg;

    // Helpers
    logic [13:0] p_w;
    logic [23:0] p_ext;
    logic [23:0] c_ext;
    logic [23:0] base_val;
    logic        base_leap;
    logic        mon_more;
    logic        date_ok;
    logic        out_of_range;
    logic        dleap;
    logic        dmon_more;
    logic        out_free;

    assign in_op    = s_tuser;
    assign in_year  = s_tdata[13:0];
    assign in_month = s_tdata[17:14];
    assign in_day   = s_tdata[22:18];
    assign in_off   = s_tdata[45:23];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, o_status_reg, o_lt_reg, o_eq_reg, o_gt_reg, o_diff_reg,
                       o_day_reg, o_month_reg, o_year_reg};

    assign out_free = !m_valid_reg || m_tready;

    // Serial base: 365*p + p/4 - p/100 + p/400 + day - 1, with p = year - 1.
    // After the century loop, cent_reg holds p/100 and acc_reg holds p%100.
    assign p_w      = yr_reg - 14'd1;
    assign p_ext    = {10'd0, p_w};
    assign c_ext    = {16'd0, cent_reg};
    assign base_val = p_ext * DAYS_1Y + (p_ext >> 2) - c_ext + (c_ext >> 2)
                      + {19'd0, dy_reg} - 24'd1;
    // Year divisible by 4 when p%4 is 3; by 100 when p%100 is 99; by 400 when
    // additionally p/100 mod 4 is 3
    assign base_leap = (p_w[1:0] == 2'b11)
                       && ((acc_reg[6:0] != 7'd99) || (cent_reg[1:0] == 2'b11));

    assign mon_more = (k_reg < mo_reg) && (k_reg <= MONTHS);

    assign date_ok = (yr_reg != 14'd0) && (yr_reg <= MAX_YEAR)
                     && (mo_reg != 4'd0) && (mo_reg <= MONTHS)
                     && (dy_reg != 5'd0) && (dy_reg <= days_in_month(mo_reg, leap_reg));

    assign out_of_range = acc_reg[23] || (acc_reg[22:0] > MAX_SERIAL);

    // Leap year from the block counts: last year of a 4-year block, and not
    // the last block of a century unless the century closes a 400-year cycle
    assign dleap = (d_reg == 2'd3) && ((c_reg != 5'd24) || (b_reg == 2'd3));

    assign dmon_more = (mo_reg < MONTHS) && !alu_neg;

    // Operand select for the shared adder
    always_comb begin
        alu_b   = 24'd0;
        alu_sub = 1'b0;
        unique case (state_reg)
            S_CENT: begin
                alu_b   = {17'd0, CENTURY};
                alu_sub = 1'b1;
            end
            S_MON: begin
                alu_b = {19'd0, days_in_month(k_reg, leap_reg)};
            end
            S_CHECK: begin
                if (op_reg == OP_ADD) begin
                    alu_b = {off_reg[22], off_reg};
                end else begin
                    alu_b   = opser_reg;
                    alu_sub = 1'b1;
                end
            end
            S_Q400: begin
                alu_b   = DAYS_400Y;
                alu_sub = 1'b1;
            end
            S_Q100: begin
                alu_b   = DAYS_100Y;
                alu_sub = 1'b1;
            end
            S_Q4: begin
                alu_b   = DAYS_4Y;
                alu_sub = 1'b1;
            end
            S_Q1: begin
                alu_b   = DAYS_1Y;
                alu_sub = 1'b1;
            end
            S_DMON: begin
                alu_b   = {19'd0, days_in_month(mo_reg, dleap)};
                alu_sub = 1'b1;
            end
            default: begin
                alu_b   = 24'd0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res = alu_sub ? (acc_reg - alu_b) : (acc_reg + alu_b);
    assign alu_neg = alu_res[23];

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = (in_op == OP_NOP) ? S_OUT : S_CENT;
                end
            end
            S_CENT: begin
                if (alu_neg) begin
                    state_next = S_BASE;
                end
            end
            S_BASE: state_next = S_MON;
            S_MON: begin
                if (!mon_more) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                unique case (op_reg)
                    OP_ADD:  state_next = S_RANGE;
                    OP_CMP:  state_next = pass_reg ? S_OUT : S_CENT;
                    default: state_next = S_OUT;
                endcase
            end
            S_RANGE: state_next = out_of_range ? S_OUT : S_Q400;
            S_Q400: begin
                if (alu_neg) begin
                    state_next = S_Q100;
                end
            end
            S_Q100: begin
                if (alu_neg || b_reg == 2'd3) begin
                    state_next = S_Q4;
                end
            end
            S_Q4: begin
                if (alu_neg) begin
                    state_next = S_Q1;
                end
            end
            S_Q1: begin
                if (alu_neg || d_reg == 2'd3) begin
                    state_next = S_DMON;
                end
            end
            S_DMON: begin
                if (!dmon_more) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        op_next        = op_reg;
        off_next       = off_reg;
        yr_next        = yr_reg;
        mo_next        = mo_reg;
        dy_next        = dy_reg;
        acc_next       = acc_reg;
        opser_next     = opser_reg;
        cent_next      = cent_reg;
        k_next         = k_reg;
        leap_next      = leap_reg;
        pass_next      = pass_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        status_next    = status_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        o_year_next    = o_year_reg;
        o_month_next   = o_month_reg;
        o_day_next     = o_day_reg;
        o_diff_next    = o_diff_reg;
        o_gt_next      = o_gt_reg;
        o_eq_next      = o_eq_reg;
        o_lt_next      = o_lt_reg;
        o_status_next  = o_status_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next     = in_op;
                    off_next    = in_off;
                    status_next = STAT_OK;
                    pass_next   = 1'b0;
                    cent_next   = 8'd0;
                    // Add converts the held date; load and compare the operand
                    if (in_op == OP_ADD) begin
                        yr_next  = cur_year_reg;
                        mo_next  = cur_month_reg;
                        dy_next  = cur_day_reg;
                        acc_next = {10'd0, cur_year_reg - 14'd1};
                    end else begin
                        yr_next  = in_year;
                        mo_next  = in_month;
                        dy_next  = in_day;
                        acc_next = {10'd0, in_year - 14'd1};
                    end
                end
            end
            S_CENT: begin
                // Strip one century per cycle
                if (!alu_neg) begin
                    acc_next  = alu_res;
                    cent_next = cent_reg + 8'd1;
                end
            end
            S_BASE: begin
                leap_next = base_leap;
                acc_next  = base_val;
                k_next    = 4'd1;
            end
            S_MON: begin
                if (mon_more) begin
                    acc_next = alu_res;
                    k_next   = k_reg + 4'd1;
                end
            end
            S_CHECK: begin
                unique case (op_reg)
                    OP_LOAD: begin
                        if (date_ok) begin
                            cur_year_next  = yr_reg;
                            cur_month_next = mo_reg;
                            cur_day_next   = dy_reg;
                        end else begin
                            cur_year_next  = DEF_YEAR;
                            cur_month_next = 4'd1;
                            cur_day_next   = 5'd1;
                            status_next    = STAT_INVALID;
                        end
                    end
                    OP_ADD: begin
                        acc_next = alu_res;
                    end
                    OP_CMP: begin
                        if (!pass_reg) begin
                            // Keep the operand serial, then convert the held date
                            opser_next  = date_ok ? acc_reg : DEF_SERIAL;
                            status_next = date_ok ? STAT_OK : STAT_INVALID;
                            yr_next     = cur_year_reg;
                            mo_next     = cur_month_reg;
                            dy_next     = cur_day_reg;
                            acc_next    = {10'd0, cur_year_reg - 14'd1};
                            cent_next   = 8'd0;
                            pass_next   = 1'b1;
                        end else begin
                            acc_next = alu_res;
                        end
                    end
                    default: begin
                        acc_next = acc_reg;
                    end
                endcase
            end
            S_RANGE: begin
                if (out_of_range) begin
                    status_next = STAT_RANGE;
                end else begin
                    yr_next = 14'd1;
                    mo_next = 4'd1;
                    b_next  = 2'd0;
                    c_next  = 5'd0;
                    d_next  = 2'd0;
                end
            end
            S_Q400: begin
                if (!alu_neg) begin
                    acc_next = alu_res;
                    yr_next  = yr_reg + 14'd400;
                end
            end
            S_Q100: begin
                if (!alu_neg && b_reg != 2'd3) begin
                    acc_next = alu_res;
                    yr_next  = yr_reg + 14'd100;
                    b_next   = b_reg + 2'd1;
                end
            end
            S_Q4: begin
                if (!alu_neg) begin
                    acc_next = alu_res;
                    yr_next  = yr_reg + 14'd4;
                    c_next   = c_reg + 5'd1;
                end
            end
            S_Q1: begin
                if (!alu_neg && d_reg != 2'd3) begin
                    acc_next = alu_res;
                    yr_next  = yr_reg + 14'd1;
                    d_next   = d_reg + 2'd1;
                end
            end
            S_DMON: begin
                if (dmon_more) begin
                    acc_next = alu_res;
                    mo_next  = mo_reg + 4'd1;
                end else begin
                    cur_year_next  = yr_reg;
                    cur_month_next = mo_reg;
                    cur_day_next   = acc_reg[4:0] + 5'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_year_next   = cur_year_reg;
                    o_month_next  = cur_month_reg;
                    o_day_next    = cur_day_reg;
                    o_status_next = status_reg;
                    if (op_reg == OP_CMP) begin
                        o_diff_next = acc_reg[22:0];
                        o_gt_next   = !acc_reg[23] && (acc_reg != 24'd0);
                        o_eq_next   = (acc_reg == 24'd0);
                        o_lt_next   = acc_reg[23];
                    end else begin
                        o_diff_next = 23'd0;
                        o_gt_next   = 1'b0;
                        o_eq_next   = 1'b0;
                        o_lt_next   = 1'b0;
                    end
                end
            end
            default: begin
                acc_next = acc_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cur_year_reg  <= 14'd1998;
            cur_month_reg <= 4'd8;
            cur_day_reg   <= 5'd28;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_year_reg  <= cur_year_next;
            cur_month_reg <= cur_month_next;
            cur_day_reg   <= cur_day_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Working and result registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        off_reg      <= off_next;
        yr_reg       <= yr_next;
        mo_reg       <= mo_next;
        dy_reg       <= dy_next;
        acc_reg      <= acc_next;
        opser_reg    <= opser_next;
        cent_reg     <= cent_next;
        k_reg        <= k_next;
        leap_reg     <= leap_next;
        pass_reg     <= pass_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        status_reg   <= status_next;
        o_year_reg   <= o_year_next;
        o_month_reg  <= o_month_next;
        o_day_reg    <= o_day_next;
        o_diff_reg   <= o_diff_next;
        o_gt_reg     <= o_gt_next;
        o_eq_reg     <= o_eq_next;
        o_lt_reg     <= o_lt_next;
        o_status_reg <= o_status_next;
    end

endmodule

`default_nettype wire
